// File: hdl/mspc_pkg.sv
// shared types, constants and register map of the motor speed pi controller
package mspc_pkg;

   // configuration port geometry
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   // datapath widths
   localparam int FREQ_WIDTH = 16;
   localparam int ERR_WIDTH  = 17;
   localparam int PROD_WIDTH = 33;
   localparam int ACC_WIDTH  = 26;
   localparam int SUM_WIDTH  = 35;
   localparam int DUTY_WIDTH = 10;
   localparam int CMP_WIDTH  = 11;
   localparam int TICK_WIDTH = 6;

   // register indexes, byte address is four times the index
   typedef enum logic [2:0] {
      REG_SPEED_SETPOINT    = 3'd0,
      REG_PROPORTIONAL_GAIN = 3'd1,
      REG_INTEGRAL_GAIN     = 3'd2,
      REG_STARTUP_TICKS     = 3'd3,
      REG_PEAK_TEST_TICKS   = 3'd4,
      REG_KICKSTART_COMPARE = 3'd5
   } reg_index_type;

   // control phase codes as reported on the result channel
   typedef enum logic [1:0] {
      PHASE_STARTUP    = 2'd0,
      PHASE_MAX_TEST   = 2'd1,
      PHASE_STALLED    = 2'd2,
      PHASE_REGULATING = 2'd3
   } phase_type;

   // register reset values
   localparam logic [15:0] SETPOINT_RESET    = 16'd6400;
   localparam logic [15:0] KP_RESET          = 16'd4915;
   localparam logic [15:0] KI_RESET          = 16'd328;
   localparam logic [5:0]  STARTUP_RESET     = 6'd15;
   localparam logic [5:0]  MAX_TEST_RESET    = 6'd20;
   localparam logic [10:0] KICKSTART_RESET   = 11'd650;

   // control law constants
   localparam logic [10:0] PWM_PERIOD        = 11'd1024;
   localparam logic [9:0]  DUTY_MAX          = 10'd1015;
   localparam logic [9:0]  DUTY_MIN          = 10'd250;
   localparam logic [10:0] TEST_DUTY         = 11'd1000;
   localparam logic [9:0]  PREV_DUTY_RESET   = 10'd650;
   localparam logic [10:0] HELD_DUTY_RESET   = 11'd512;
   localparam logic [15:0] STALL_FREQ        = 16'd160;
   localparam logic signed [16:0] BIG_ERROR  = 17'sd1296;
   localparam logic [9:0]  STEP_BIG          = 10'd80;
   localparam logic [9:0]  STEP_SMALL        = 10'd24;
   localparam logic signed [33:0] INTEG_LIMIT = 34'sd26214400;
   // q.16 thresholds: whole duty >= 1015, and whole duty <= 250 (u < 251.0)
   localparam logic signed [34:0] U_HIGH     = 35'sd66519040;
   localparam logic signed [34:0] U_LOW      = 35'sd16449536;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [15:0] speed_setpoint;
      logic [15:0] proportional_gain;
      logic [15:0] integral_gain;
      logic [5:0]  startup_ticks;
      logic [5:0]  peak_test_ticks;
      logic [10:0] kickstart_compare;
   } cfg_type;

   // product stage contents handed to the control law stage
   typedef struct packed {
      logic [15:0]        freq;
      logic signed [16:0] err;
      logic signed [32:0] p_term;
      logic signed [32:0] i_term;
   } prod_type;

endpackage

// File: hdl/mspc_csr.sv
// apb register bank holding the controller settings
module mspc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mspc_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [mspc_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [mspc_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output mspc_pkg::cfg_type                   cfg
);
   import mspc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = reg_index_type'(paddr[4:2]);
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SPEED_SETPOINT:    cfg_in.speed_setpoint    = pwdata[15:0];
            REG_PROPORTIONAL_GAIN: cfg_in.proportional_gain = pwdata[15:0];
            REG_INTEGRAL_GAIN:     cfg_in.integral_gain     = pwdata[15:0];
            REG_STARTUP_TICKS:     cfg_in.startup_ticks     = pwdata[5:0];
            REG_PEAK_TEST_TICKS:   cfg_in.peak_test_ticks   = pwdata[5:0];
            REG_KICKSTART_COMPARE: cfg_in.kickstart_compare = pwdata[10:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_setpoint    <= SETPOINT_RESET;
         cfg_ff.proportional_gain <= KP_RESET;
         cfg_ff.integral_gain     <= KI_RESET;
         cfg_ff.startup_ticks     <= STARTUP_RESET;
         cfg_ff.peak_test_ticks   <= MAX_TEST_RESET;
         cfg_ff.kickstart_compare <= KICKSTART_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         REG_SPEED_SETPOINT:    prdata = {16'd0, cfg_ff.speed_setpoint};
         REG_PROPORTIONAL_GAIN: prdata = {16'd0, cfg_ff.proportional_gain};
         REG_INTEGRAL_GAIN:     prdata = {16'd0, cfg_ff.integral_gain};
         REG_STARTUP_TICKS:     prdata = {26'd0, cfg_ff.startup_ticks};
         REG_PEAK_TEST_TICKS:   prdata = {26'd0, cfg_ff.peak_test_ticks};
         REG_KICKSTART_COMPARE: prdata = {21'd0, cfg_ff.kickstart_compare};
         default:               prdata = '0;
      endcase
   end

endmodule

// File: hdl/mspc_mul.sv
// input register and gain product stage
module mspc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [15:0]          req_measured_frequency,
   input  mspc_pkg::cfg_type    cfg,
   output logic                 prod_valid,
   input  logic                 prod_ready,
   output mspc_pkg::prod_type   prod
);
   import mspc_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [15:0]        in_freq_ff;
   logic               prod_valid_ff;
   logic               prod_valid_in;
   prod_type           prod_ff;
   prod_type           prod_in;
   logic               in_take;
   logic               mul_take;
   logic signed [33:0] p_full;
   logic signed [33:0] i_full;

   // pipeline flow, each stage moves when the one after it has room
   assign mul_take    = !prod_valid_ff || prod_ready;
   assign in_take     = !in_valid_ff || mul_take;
   assign req_stall   = !in_take;
   assign in_valid_in = in_take ? req_valid : 1'b1;
   assign prod_valid_in = mul_take ? in_valid_ff : 1'b1;

   // speed error and both gain products
   always_comb begin
      prod_in.freq   = in_freq_ff;
      prod_in.err    = $signed({1'b0, cfg.speed_setpoint}) - $signed({1'b0, in_freq_ff});
      p_full         = $signed({1'b0, cfg.proportional_gain}) * prod_in.err;
      i_full         = $signed({1'b0, cfg.integral_gain}) * prod_in.err;
      prod_in.p_term = p_full[32:0];
      prod_in.i_term = i_full[32:0];
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_freq_ff <= req_measured_frequency;
      end
      if (mul_take) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

// File: hdl/mspc_law.sv
// phase sequencing, pi law with anti-windup, clamp and slew limit, result register
module mspc_law (
   input  logic                clock,
   input  logic                reset,
   input  logic                prod_valid,
   output logic                prod_ready,
   input  mspc_pkg::prod_type  prod,
   input  mspc_pkg::cfg_type   cfg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [10:0]         rsp_pwm_compare,
   output logic [10:0]         rsp_duty_command,
   output logic signed [9:0]   rsp_integrator_whole,
   output logic                rsp_saturated_high,
   output logic                rsp_saturated_low,
   output logic [15:0]         rsp_peak_frequency,
   output logic [1:0]          rsp_control_phase
);
   import mspc_pkg::*;

   // controller state
   logic [5:0]          startup_count_ff, startup_count_in;
   logic [5:0]          max_test_count_ff, max_test_count_in;
   logic signed [25:0]  acc_ff, acc_in;
   logic [9:0]          prev_duty_ff, prev_duty_in;
   logic [10:0]         held_duty_ff, held_duty_in;
   logic [15:0]         peak_ff, peak_in;
   logic                high_flag_ff, high_flag_in;
   logic                low_flag_ff, low_flag_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [10:0]         compare_ff, compare_in;
   phase_type           phase_ff, phase_in;
   logic signed [9:0]   whole_ff, whole_in;

   // datapath
   logic                load;
   logic signed [34:0]  base;
   logic signed [34:0]  p_wide;
   logic signed [34:0]  u_first;
   logic signed [34:0]  u_second;
   logic                hold_integ;
   logic signed [33:0]  acc_sum;
   logic signed [25:0]  acc_clamped;
   logic signed [25:0]  acc_reg;
   logic [9:0]          duty_clamped;
   logic [9:0]          step;
   logic signed [10:0]  delta;
   logic signed [10:0]  step_s;
   logic [9:0]          duty_new;
   logic [15:0]         peak_upd;

   // negative integrator limit in accumulator width
   function automatic logic signed [25:0] acc_sum_neg_limit();
      logic signed [33:0] neg;
      neg = -INTEG_LIMIT;
      return neg[25:0];
   endfunction

   assign prod_ready   = !rsp_valid_ff || !rsp_stall;
   assign load         = prod_valid && prod_ready;
   assign rsp_valid_in = prod_ready ? prod_valid : 1'b1;

   // pi law for the regulating phase
   always_comb begin
      base     = $signed({9'd0, prev_duty_ff, 16'd0});
      p_wide   = $signed({{2{prod.p_term[32]}}, prod.p_term});
      u_first  = base + p_wide + $signed({{9{acc_ff[25]}}, acc_ff});

      // anti-windup: stop integrating while pushing further into a limit
      hold_integ = ((u_first >= U_HIGH) && (prod.err > 17'sd0)) ||
                   ((u_first < U_LOW) && prod.err[16]);

      acc_sum = $signed({{8{acc_ff[25]}}, acc_ff}) + $signed({prod.i_term[32], prod.i_term});
      if (acc_sum > INTEG_LIMIT) begin
         acc_clamped = INTEG_LIMIT[25:0];
      end else if (acc_sum < -INTEG_LIMIT) begin
         acc_clamped = acc_sum_neg_limit();
      end else begin
         acc_clamped = acc_sum[25:0];
      end
      acc_reg = hold_integ ? acc_ff : acc_clamped;

      u_second = base + p_wide + $signed({{9{acc_reg[25]}}, acc_reg});
      if (u_second >= U_HIGH) begin
         duty_clamped = DUTY_MAX;
      end else if (u_second < U_LOW) begin
         duty_clamped = DUTY_MIN;
      end else begin
         duty_clamped = u_second[25:16];
      end

      // slew limit, wider step when the error magnitude reaches BIG_ERROR
      step   = ((prod.err >= BIG_ERROR) || (prod.err <= -BIG_ERROR)) ? STEP_BIG : STEP_SMALL;
      step_s = $signed({1'b0, step});
      delta  = $signed({1'b0, duty_clamped}) - $signed({1'b0, prev_duty_ff});
      if (delta > step_s) begin
         duty_new = prev_duty_ff + step;
      end else if (delta < -step_s) begin
         duty_new = prev_duty_ff - step;
      end else begin
         duty_new = duty_clamped;
      end

      peak_upd = (prod.freq > peak_ff) ? prod.freq : peak_ff;
   end

   // phase selection and state update
   always_comb begin
      startup_count_in  = startup_count_ff;
      max_test_count_in = max_test_count_ff;
      acc_in            = acc_ff;
      prev_duty_in      = prev_duty_ff;
      held_duty_in      = held_duty_ff;
      peak_in           = peak_ff;
      high_flag_in      = high_flag_ff;
      low_flag_in       = low_flag_ff;
      compare_in        = compare_ff;
      phase_in          = phase_ff;

      if (load) begin
         if (startup_count_ff < cfg.startup_ticks) begin
            startup_count_in = startup_count_ff + 6'd1;
            compare_in       = cfg.kickstart_compare;
            acc_in           = '0;
            phase_in         = PHASE_STARTUP;
         end else if (max_test_count_ff < cfg.peak_test_ticks) begin
            peak_in           = peak_upd;
            held_duty_in      = TEST_DUTY;
            compare_in        = PWM_PERIOD - TEST_DUTY;
            max_test_count_in = max_test_count_ff + 6'd1;
            phase_in          = PHASE_MAX_TEST;
         end else if (prod.freq < STALL_FREQ) begin
            compare_in = cfg.kickstart_compare;
            acc_in     = '0;
            phase_in   = PHASE_STALLED;
         end else begin
            peak_in      = peak_upd;
            acc_in       = acc_reg;
            held_duty_in = {1'b0, duty_new};
            compare_in   = PWM_PERIOD - {1'b0, duty_new};
            high_flag_in = (duty_new >= DUTY_MAX);
            low_flag_in  = (duty_new <= DUTY_MIN);
            prev_duty_in = duty_new;
            phase_in     = PHASE_REGULATING;
         end
      end

      // integrator in whole counts, truncated toward zero
      whole_in = acc_in[25:16] + {9'd0, (acc_in[25] && (acc_in[15:0] != 16'd0))};
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         startup_count_ff  <= '0;
         max_test_count_ff <= '0;
         acc_ff            <= '0;
         prev_duty_ff      <= PREV_DUTY_RESET;
         held_duty_ff      <= HELD_DUTY_RESET;
         peak_ff           <= '0;
         high_flag_ff      <= 1'b0;
         low_flag_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         startup_count_ff  <= startup_count_in;
         max_test_count_ff <= max_test_count_in;
         acc_ff            <= acc_in;
         prev_duty_ff      <= prev_duty_in;
         held_duty_ff      <= held_duty_in;
         peak_ff           <= peak_in;
         high_flag_ff      <= high_flag_in;
         low_flag_ff       <= low_flag_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         compare_ff <= compare_in;
         phase_ff   <= phase_in;
         whole_ff   <= whole_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pwm_compare      = compare_ff;
   assign rsp_duty_command     = held_duty_ff;
   assign rsp_integrator_whole = whole_ff;
   assign rsp_saturated_high   = high_flag_ff;
   assign rsp_saturated_low    = low_flag_ff;
   assign rsp_peak_frequency   = peak_ff;
   assign rsp_control_phase    = phase_ff;

   // previous duty stays within the regulating range
   assert property (@(posedge clock) disable iff (reset)
      (prev_duty_ff >= DUTY_MIN) && (prev_duty_ff <= DUTY_MAX))
      else $error("previous duty outside regulating range");

   // integrator stays within its clamp
   assert property (@(posedge clock) disable iff (reset)
      ($signed({{8{acc_ff[25]}}, acc_ff}) <= INTEG_LIMIT) &&
      ($signed({{8{acc_ff[25]}}, acc_ff}) >= -INTEG_LIMIT))
      else $error("integrator beyond clamp");

   // regulated compare is the inverse of the commanded duty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (phase_ff == PHASE_REGULATING)) |->
      (compare_ff == PWM_PERIOD - held_duty_ff))
      else $error("compare does not match duty");

   // kickstart phases leave a cleared integrator
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((phase_ff == PHASE_STARTUP) || (phase_ff == PHASE_STALLED))) |->
      (whole_ff == 10'sd0))
      else $error("integrator not cleared in kickstart");

   // state moves only with a transaction
   assert property (@(posedge clock) disable iff (reset)
      !load |=> ($stable(prev_duty_ff) && $stable(acc_ff) && $stable(peak_ff)))
      else $error("state changed without transaction");

endmodule

// File: hdl/motor_speed_pi_controller.sv
// top level of the motor speed pi controller
// a request passes through the input register and the product register to the result register;
// one transaction per cycle while no stall holds the pipeline; the gain multipliers have a stage of their own
// and the control law with its state update sits in the result stage
// reset: synchronous, restores the register defaults, empties the pipeline and
// restarts the startup phase
module motor_speed_pi_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_measured_frequency,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [10:0]                         rsp_pwm_compare,
   output logic [10:0]                         rsp_duty_command,
   output logic signed [9:0]                   rsp_integrator_whole,
   output logic                                rsp_saturated_high,
   output logic                                rsp_saturated_low,
   output logic [15:0]                         rsp_peak_frequency,
   output logic [1:0]                          rsp_control_phase,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mspc_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [mspc_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [mspc_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import mspc_pkg::*;

   cfg_type  cfg;
   prod_type prod;
   logic     prod_valid;
   logic     prod_ready;

   // settings registers
   mspc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register and gain products
   mspc_mul u_mul (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_measured_frequency (req_measured_frequency),
      .cfg                    (cfg),
      .prod_valid             (prod_valid),
      .prod_ready             (prod_ready),
      .prod                   (prod)
   );

   // control law and result register
   mspc_law u_law (
      .clock                (clock),
      .reset                (reset),
      .prod_valid           (prod_valid),
      .prod_ready           (prod_ready),
      .prod                 (prod),
      .cfg                  (cfg),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pwm_compare      (rsp_pwm_compare),
      .rsp_duty_command     (rsp_duty_command),
      .rsp_integrator_whole (rsp_integrator_whole),
      .rsp_saturated_high   (rsp_saturated_high),
      .rsp_saturated_low    (rsp_saturated_low),
      .rsp_peak_frequency   (rsp_peak_frequency),
      .rsp_control_phase    (rsp_control_phase)
   );

endmodule

// File: tb/motor_speed_pi_checker.sv
// checker for the motor speed pi controller: predicts each control tick and compares results
`timescale 1ns / 100ps

module motor_speed_pi_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_measured_frequency,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [10:0] rsp_pwm_compare,
   input  logic [10:0] rsp_duty_command,
   input  logic [9:0]  rsp_integrator_whole,
   input  logic        rsp_saturated_high,
   input  logic        rsp_saturated_low,
   input  logic [15:0] rsp_peak_frequency,
   input  logic [1:0]  rsp_control_phase,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          outstanding
);
   import mspc_pkg::*;

   // control law limits as plain integers
   localparam int    PERIOD_I     = PWM_PERIOD;
   localparam int    DUTY_HI      = DUTY_MAX;
   localparam int    DUTY_LO      = DUTY_MIN;
   localparam int    DUTY_CEIL    = PWM_PERIOD;
   localparam int    BIG_ERR      = BIG_ERROR;
   localparam int    STEP_FAST    = STEP_BIG;
   localparam int    STEP_SLOW    = STEP_SMALL;
   localparam longint INTEG_LIM   = INTEG_LIMIT;

   typedef struct packed {
      logic [10:0]       pwm_compare;
      logic [10:0]       duty_command;
      logic signed [9:0] integrator_whole;
      logic              saturated_high;
      logic              saturated_low;
      logic [15:0]       peak_frequency;
      phase_type         control_phase;
   } tick_result_type;

   // register copies
   logic [15:0] cfg_setpoint;
   logic [15:0] cfg_prop_gain;
   logic [15:0] cfg_int_gain;
   logic [5:0]  cfg_startup_ticks;
   logic [5:0]  cfg_peak_test_ticks;
   logic [10:0] cfg_kick_compare;

   // controller state copies
   logic [5:0]  startup_done;
   logic [5:0]  max_test_done;
   longint      integ_q16;
   int          last_duty;
   logic [10:0] held_duty;
   logic [15:0] peak_freq;
   logic        sat_hi;
   logic        sat_lo;

   tick_result_type pending_ticks[$];
   int mismatches;

   // q.16 to whole counts, truncated toward zero
   function automatic int q16_whole(input longint v);
      return int'(v / 64'sd65536);
   endfunction

   function automatic int clamp_duty(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // one control tick: phase selection, pi law, anti-windup and slew limit
   function automatic tick_result_type control_law_step(input logic [15:0] freq);
      tick_result_type r;
      longint err, prop, base;
      int duty, step, delta;
      logic [10:0] cmp;
      phase_type ph;
      if (startup_done < cfg_startup_ticks) begin
         startup_done++;
         cmp = cfg_kick_compare;
         integ_q16 = 0;
         ph = PHASE_STARTUP;
      end else if (max_test_done < cfg_peak_test_ticks) begin
         if (freq > peak_freq) peak_freq = freq;
         held_duty = TEST_DUTY;
         cmp = 11'(PWM_PERIOD - TEST_DUTY);
         max_test_done++;
         ph = PHASE_MAX_TEST;
      end else if (freq < STALL_FREQ) begin
         cmp = cfg_kick_compare;
         integ_q16 = 0;
         ph = PHASE_STALLED;
      end else begin
         err  = longint'(cfg_setpoint) - longint'(freq);
         prop = longint'(cfg_prop_gain) * err;
         base = longint'(last_duty) * 65536;
         if (freq > peak_freq) peak_freq = freq;
         // first duty decides whether the integrator may move
         duty = clamp_duty(q16_whole(base + prop + integ_q16), DUTY_LO, DUTY_CEIL);
         if (!((duty >= DUTY_HI && err > 0) || (duty <= DUTY_LO && err < 0))) begin
            integ_q16 += longint'(cfg_int_gain) * err;
            if (integ_q16 > INTEG_LIM) integ_q16 = INTEG_LIM;
            if (integ_q16 < -INTEG_LIM) integ_q16 = -INTEG_LIM;
         end
         duty = clamp_duty(q16_whole(base + prop + integ_q16), DUTY_LO, DUTY_HI);
         // slew limit, wider step on a large error
         step = (err >= BIG_ERR || err <= -BIG_ERR) ? STEP_FAST : STEP_SLOW;
         delta = duty - last_duty;
         if (delta > step) duty = last_duty + step;
         else if (delta < -step) duty = last_duty - step;
         held_duty = 11'(duty);
         cmp = 11'(PERIOD_I - duty);
         sat_hi = (duty >= DUTY_HI);
         sat_lo = (duty <= DUTY_LO);
         last_duty = duty;
         ph = PHASE_REGULATING;
      end
      r.pwm_compare      = cmp;
      r.duty_command     = held_duty;
      r.integrator_whole = 10'(q16_whole(integ_q16));
      r.saturated_high   = sat_hi;
      r.saturated_low    = sat_lo;
      r.peak_frequency   = peak_freq;
      r.control_phase    = ph;
      return r;
   endfunction

   always @(posedge clock) begin
      tick_result_type seen, want;
      if (reset) begin
         cfg_setpoint        = SETPOINT_RESET;
         cfg_prop_gain       = KP_RESET;
         cfg_int_gain        = KI_RESET;
         cfg_startup_ticks   = STARTUP_RESET;
         cfg_peak_test_ticks = MAX_TEST_RESET;
         cfg_kick_compare    = KICKSTART_RESET;
         startup_done  = '0;
         max_test_done = '0;
         integ_q16     = 0;
         last_duty     = PREV_DUTY_RESET;
         held_duty     = HELD_DUTY_RESET;
         peak_freq     = '0;
         sat_hi        = 1'b0;
         sat_lo        = 1'b0;
         mismatches    = 0;
         pending_ticks.delete();
      end else begin
         // register write transaction
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_SPEED_SETPOINT:    cfg_setpoint        = pwdata[15:0];
               REG_PROPORTIONAL_GAIN: cfg_prop_gain       = pwdata[15:0];
               REG_INTEGRAL_GAIN:     cfg_int_gain        = pwdata[15:0];
               REG_STARTUP_TICKS:     cfg_startup_ticks   = pwdata[5:0];
               REG_PEAK_TEST_TICKS:   cfg_peak_test_ticks = pwdata[5:0];
               REG_KICKSTART_COMPARE: cfg_kick_compare    = pwdata[10:0];
               default: ;
            endcase
         end
         // accepted tick transaction
         if (req_valid && !req_stall)
            pending_ticks.push_back(control_law_step(req_measured_frequency));
         // accepted result transaction
         if (rsp_valid && !rsp_stall) begin
            seen.pwm_compare      = rsp_pwm_compare;
            seen.duty_command     = rsp_duty_command;
            seen.integrator_whole = rsp_integrator_whole;
            seen.saturated_high   = rsp_saturated_high;
            seen.saturated_low    = rsp_saturated_low;
            seen.peak_frequency   = rsp_peak_frequency;
            seen.control_phase    = phase_type'(rsp_control_phase);
            if (pending_ticks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with no tick pending: cmp=%0d duty=%0d phase=%0d",
                           $time, seen.pwm_compare, seen.duty_command, seen.control_phase);
            end else begin
               want = pending_ticks.pop_front();
               if (seen.pwm_compare !== want.pwm_compare ||
                   seen.duty_command !== want.duty_command ||
                   seen.integrator_whole !== want.integrator_whole ||
                   seen.saturated_high !== want.saturated_high ||
                   seen.saturated_low !== want.saturated_low ||
                   seen.peak_frequency !== want.peak_frequency ||
                   seen.control_phase !== want.control_phase) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"%0t: mismatch expected cmp=%0d duty=%0d integ=%0d",
                               " hi=%0b lo=%0b peak=%0d phase=%0d"},
                              $time, want.pwm_compare, want.duty_command,
                              want.integrator_whole, want.saturated_high,
                              want.saturated_low, want.peak_frequency, want.control_phase);
                     $display({"%0t: mismatch actual   cmp=%0d duty=%0d integ=%0d",
                               " hi=%0b lo=%0b peak=%0d phase=%0d"},
                              $time, seen.pwm_compare, seen.duty_command,
                              seen.integrator_whole, seen.saturated_high,
                              seen.saturated_low, seen.peak_frequency, seen.control_phase);
                  end
               end
            end
         end
      end
      fail_count  <= mismatches;
      outstanding <= pending_ticks.size();
   end

endmodule

// File: tb/motor_speed_pi_controller_tb.sv
// testbench top of the motor speed pi controller: stimulus, configuration and verdict
`timescale 1ns / 100ps

module motor_speed_pi_controller_tb;
   import mspc_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_measured_frequency;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [10:0] rsp_pwm_compare;
   logic [10:0] rsp_duty_command;
   logic signed [9:0] rsp_integrator_whole;
   logic        rsp_saturated_high;
   logic        rsp_saturated_low;
   logic [15:0] rsp_peak_frequency;
   logic [1:0]  rsp_control_phase;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic        pready;

   int fail_count;
   int outstanding;

   // stimulus control
   bit tx_idling;
   bit rx_idling;
   bit hold_off_req;
   int cur_setpoint;
   int run_left = 0;
   int run_centre;
   int run_spread;

   // startup, max test, stall threshold, step boundaries, then ramps into saturation
   logic [15:0] directed_freqs [25] = '{
      16'd100, 16'd65535,
      16'd65535, 16'd0, 16'd1000,
      16'd159, 16'd160, 16'd6400, 16'd5105, 16'd5104, 16'd7695, 16'd7696,
      16'd65535, 16'd0,
      16'd200, 16'd200, 16'd200, 16'd200, 16'd200, 16'd200,
      16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535
   };

   always #5 clock = ~clock;

   motor_speed_pi_controller DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_measured_frequency(req_measured_frequency),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pwm_compare(rsp_pwm_compare), .rsp_duty_command(rsp_duty_command),
      .rsp_integrator_whole(rsp_integrator_whole),
      .rsp_saturated_high(rsp_saturated_high), .rsp_saturated_low(rsp_saturated_low),
      .rsp_peak_frequency(rsp_peak_frequency), .rsp_control_phase(rsp_control_phase),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   motor_speed_pi_checker law_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_measured_frequency(req_measured_frequency),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pwm_compare(rsp_pwm_compare), .rsp_duty_command(rsp_duty_command),
      .rsp_integrator_whole(rsp_integrator_whole),
      .rsp_saturated_high(rsp_saturated_high), .rsp_saturated_low(rsp_saturated_low),
      .rsp_peak_frequency(rsp_peak_frequency), .rsp_control_phase(rsp_control_phase),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   // frequency runs: mostly around the setpoint, some far off, near stall or pure noise
   function automatic logic [15:0] next_frequency();
      int v;
      if (run_left == 0) begin
         run_left = int'($urandom_range(4, 30));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               run_centre = cur_setpoint;
               run_spread = int'($urandom_range(0, 1500));
            end
            5: begin
               run_centre = int'($urandom_range(160, 2000));
               run_spread = 60;
            end
            6: begin
               run_centre = cur_setpoint + int'($urandom_range(1500, 6000));
               run_spread = 200;
            end
            7: begin
               run_centre = int'(STALL_FREQ);
               run_spread = 12;
            end
            8: begin
               run_centre = 32768;
               run_spread = 32768;
            end
            default: begin
               run_centre = int'($urandom_range(0, 1)) * 65535;
               run_spread = 0;
            end
         endcase
      end
      run_left--;
      v = run_centre - run_spread + int'($urandom_range(0, 2 * run_spread));
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // offer one tick transaction, then perhaps leave a gap
   task automatic offer_tick(input logic [15:0] freq);
      req_valid <= 1'b1;
      req_measured_frequency <= freq;
      do @(posedge clock); while (req_stall);
      if (tx_idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every pending result
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // setup then access; psel stays high between back-to-back writes
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic apply_settings(input int sp, input int kp, input int ki,
                                 input int st, input int mt, input int kc);
      csr_write(REG_SPEED_SETPOINT, 32'(sp));
      csr_write(REG_PROPORTIONAL_GAIN, 32'(kp));
      csr_write(REG_INTEGRAL_GAIN, 32'(ki));
      csr_write(REG_STARTUP_TICKS, 32'(st));
      csr_write(REG_PEAK_TEST_TICKS, 32'(mt));
      csr_write(REG_KICKSTART_COMPARE, 32'(kc));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_setpoint = sp;
   endtask

   // result side: random stall bursts and one long hold-off
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if (rx_idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   initial begin
      #4_000_000;
      $display("** motor_speed_pi_controller: FAILED **");
      $finish;
   end

   initial begin
      int phase_no, n_items, wait_cycles;
      int sp, kp, ki, st, mt, kc;
      reset   <= 1'b1;
      req_valid <= 1'b0;
      req_measured_frequency <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      hold_off_req = 1'b0;
      cur_setpoint = SETPOINT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // directed ticks with short startup and max test phases
      apply_settings(6400, 4915, 328, 2, 3, 650);
      tx_idling = 1'b1;
      rx_idling = 1'b1;
      foreach (directed_freqs[i]) offer_tick(directed_freqs[i]);

      // random phases, each under its own register setting
      for (phase_no = 0; phase_no < 10; phase_no++) begin
         n_items = 120;
         case (phase_no)
            0: begin sp = 6400; kp = 4915; ki = 328; st = 0; mt = 0; kc = 650; end
            1: begin sp = 65535; kp = 65535; ki = 65535; st = 0; mt = 0; kc = 2047; end
            2: begin sp = 0; kp = 0; ki = 0; st = 0; mt = 0; kc = 0; end
            // raised limits re-enter startup and max test
            3: begin
               sp = 6400; kp = 4915; ki = 328; st = 63; mt = 63; kc = 1024;
               n_items = 170;
            end
            // lowered limits simply end those phases
            4: begin sp = 8000; kp = 2000; ki = 100; st = 10; mt = 5; kc = 650; end
            default: begin
               sp = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(2000, 12000));
               kp = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(0, 8191));
               ki = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(0, 2047));
               st = int'($urandom_range(0, 63));
               mt = int'($urandom_range(0, 63));
               kc = int'($urandom_range(0, 2047));
            end
         endcase
         wait_idle();
         apply_settings(sp, kp, ki, st, mt, kc);
         run_left = 0;
         tx_idling = (phase_no != 9) && ($urandom_range(0, 3) != 0);
         rx_idling = (phase_no != 9) && ($urandom_range(0, 3) != 0);
         if (phase_no == 1) hold_off_req = 1'b1;
         repeat (n_items) offer_tick(next_frequency());
      end

      // drain and verdict
      req_valid <= 1'b0;
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (outstanding != 0 && wait_cycles < 20000);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("** motor_speed_pi_controller: PASSED **");
      else
         $display("** motor_speed_pi_controller: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
hdl/mspc_pkg.sv
hdl/mspc_csr.sv
hdl/mspc_mul.sv
hdl/mspc_law.sv
hdl/motor_speed_pi_controller.sv
tb/motor_speed_pi_checker.sv
tb/motor_speed_pi_controller_tb.sv
